// ===== hdl/tpft_pkg.sv =====
// ----------------------------------------------------------------------------
// tpft_pkg - shared types and constants of the touchpad finger tracker
// Finger table size, packet command format, fault and register codes.
// ----------------------------------------------------------------------------
package tpft_pkg;

  localparam int FINGER_SLOTS = 5;            // 1..7
  localparam int SLOT_W       = 3;            // width of a slot index
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FINGER_SLOTS - 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_PAD_W   = 3;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0] SIZE_LARGE = 8'hff;

  localparam logic [3:0]  TOUCH_CODE_RST = 4'd3;
  localparam logic [3:0]  ABS_CODE_RST   = 4'd6;
  localparam logic [3:0]  REL_CODE_RST   = 4'd9;
  localparam logic [15:0] Y_LIMIT_RST    = 16'd32640;

  typedef enum logic [1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_TYPE   = 2'd1,
    FAULT_FINGER = 2'd2
  } fault_e;

  typedef enum logic [1:0] {
    REG_TOUCH_CODE = 2'd0,
    REG_ABS_CODE   = 2'd1,
    REG_REL_CODE   = 2'd2,
    REG_Y_LIMIT    = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_NONE,      // no state change
    OP_TOUCH,     // load active bitmap
    OP_ABS_SET,   // load position, mark valid
    OP_ABS_DROP,  // large contact: mark invalid
    OP_REL        // add deltas to one or two fingers
  } op_e;

  typedef struct packed {
    logic [3:0] touch_code;
    logic [3:0] abs_code;
    logic [3:0] rel_code;
  } type_codes_t;

  // one decoded packet
  typedef struct packed {
    op_e                     op;
    fault_e                  fault;
    logic                    button;
    logic [FINGER_SLOTS-1:0] bitmap;
    logic                    slot_a_ok;
    logic [SLOT_W-1:0]       slot_a;
    logic                    slot_b_ok;
    logic [SLOT_W-1:0]       slot_b;
    logic [15:0]             pos_x;
    logic [15:0]             pos_y;
    logic [7:0]              dx_a;
    logic [7:0]              dy_a;
    logic [7:0]              dx_b;
    logic [7:0]              dy_b;
  } cmd_t;

endpackage

// ===== hdl/tpft_front.sv =====
// ----------------------------------------------------------------------------
// tpft_front - packet classifier
// Matches the type nibble, checks finger numbers, builds one command.
// ----------------------------------------------------------------------------
module tpft_front (
  input  logic [tpft_pkg::IN_TDATA_W-1:0] pkt_i,
  input  tpft_pkg::type_codes_t           codes_i,
  output tpft_pkg::cmd_t                  cmd_o
);

  logic [7:0] b0, b1, b2, b3, b4, b5;
  logic [3:0] kind;
  logic [3:0] abs_num;
  logic [2:0] rel_num_a;
  logic [2:0] rel_num_b;
  logic       abs_ok;
  logic       rel_a_ok;
  logic       rel_b_ok;

  assign {b5, b4, b3, b2, b1, b0} = pkt_i;
  assign kind      = b0[3:0];
  assign abs_num   = b1[7:4];
  assign rel_num_a = b0[6:4];
  assign rel_num_b = b3[6:4];

  // finger number 0 means none; n names slot n-1
  assign abs_ok   = (abs_num != 4'd0) && (abs_num <= 4'(tpft_pkg::FINGER_SLOTS));
  assign rel_a_ok = (rel_num_a != 3'd0) && (rel_num_a <= 3'(tpft_pkg::FINGER_SLOTS));
  assign rel_b_ok = (rel_num_b != 3'd0) && (rel_num_b <= 3'(tpft_pkg::FINGER_SLOTS));

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = tpft_pkg::OP_NONE;
    cmd_o.fault     = tpft_pkg::FAULT_NONE;
    cmd_o.bitmap    = b1[tpft_pkg::FINGER_SLOTS-1:0];
    cmd_o.pos_x     = {4'd0, b1[3:0], b2};
    cmd_o.pos_y     = {b3, b4};
    cmd_o.dx_a      = b1;
    cmd_o.dy_a      = b2;
    cmd_o.dx_b      = b4;
    cmd_o.dy_b      = b5;
    cmd_o.slot_b    = tpft_pkg::SLOT_W'(rel_num_b - 3'd1);
    cmd_o.slot_b_ok = rel_b_ok;
    // touch first, then absolute, then relative when codes collide
    if (kind == codes_i.touch_code) begin
      cmd_o.op     = tpft_pkg::OP_TOUCH;
      cmd_o.button = b0[4];
    end else if (kind == codes_i.abs_code) begin
      cmd_o.button = b0[4];
      cmd_o.slot_a = tpft_pkg::SLOT_W'(abs_num - 4'd1);
      if (!abs_ok) begin
        cmd_o.fault = tpft_pkg::FAULT_FINGER;
      end else if (b5 == tpft_pkg::SIZE_LARGE) begin
        cmd_o.op = tpft_pkg::OP_ABS_DROP;
      end else begin
        cmd_o.op = tpft_pkg::OP_ABS_SET;
      end
    end else if (kind == codes_i.rel_code) begin
      cmd_o.op        = tpft_pkg::OP_REL;
      cmd_o.button    = b0[7];
      cmd_o.slot_a    = tpft_pkg::SLOT_W'(rel_num_a - 3'd1);
      cmd_o.slot_a_ok = rel_a_ok;
      if (!rel_a_ok) begin
        cmd_o.fault = tpft_pkg::FAULT_FINGER;
      end
    end else begin
      cmd_o.fault = tpft_pkg::FAULT_TYPE;
    end
  end

endmodule

// ===== hdl/tpft_queue.sv =====
// ----------------------------------------------------------------------------
// tpft_queue - command queue
// Small FIFO between classifier and table engine.
// ----------------------------------------------------------------------------
module tpft_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tpft_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output tpft_pkg::cmd_t pop_data_o
);

  tpft_pkg::cmd_t                  mem_q [tpft_pkg::Q_DEPTH];
  logic [tpft_pkg::Q_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [tpft_pkg::Q_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [tpft_pkg::Q_CNT_W-1:0]    cnt_q, cnt_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o     = (cnt_q == tpft_pkg::Q_CNT_W'(tpft_pkg::Q_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == tpft_pkg::Q_PTR_W'(tpft_pkg::Q_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == tpft_pkg::Q_PTR_W'(tpft_pkg::Q_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/tpft_back.sv =====
// ----------------------------------------------------------------------------
// tpft_back - finger table engine
// Applies one command to the table, then streams one report per slot.
// ----------------------------------------------------------------------------
module tpft_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [15:0]                      y_limit_i,
  input  logic                             cmd_valid_i,
  input  tpft_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [tpft_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic [1:0]                       m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);

  localparam int N = tpft_pkg::FINGER_SLOTS;

  logic [15:0]                 x_q [N];
  logic [15:0]                 x_d [N];
  logic [15:0]                 y_q [N];
  logic [15:0]                 y_d [N];
  logic [N-1:0]                active_q, active_d;
  logic [N-1:0]                valid_q, valid_d;
  logic                        button_q, button_d;

  logic                        busy_q, busy_d;
  logic [tpft_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  tpft_pkg::fault_e            fault_q, fault_d;

  logic                        out_valid_q, out_valid_d;
  logic [tpft_pkg::SLOT_W-1:0] out_slot_q;
  logic                        out_touch_q;
  logic [15:0]                 out_x_q;
  logic [15:0]                 out_y_q;
  logic                        out_button_q;
  tpft_pkg::fault_e            out_fault_q;
  logic                        out_last_q;

  logic                        load_en;
  logic                        pop;
  logic                        rep_touch;
  logic [15:0]                 rep_x;
  logic [15:0]                 rep_y;
  logic [15:0]                 rep_yi;

  assign load_en   = !out_valid_q || m_axis_tready_i;
  // next packet enters once the last report of this one is loaded
  assign pop       = cmd_valid_i &&
                     (!busy_q || (load_en && cnt_q == tpft_pkg::LAST_SLOT));
  assign cmd_pop_o = pop;

  // table update
  always_comb begin
    x_d      = x_q;
    y_d      = y_q;
    active_d = active_q;
    valid_d  = valid_q;
    button_d = button_q;
    if (pop) begin
      if (cmd_i.op != tpft_pkg::OP_NONE) begin
        button_d = cmd_i.button;
      end
      for (int i = 0; i < N; i++) begin
        case (cmd_i.op)
          tpft_pkg::OP_TOUCH: begin
            active_d[i] = cmd_i.bitmap[i];
            if (!cmd_i.bitmap[i]) begin
              valid_d[i] = 1'b0;
            end
          end
          tpft_pkg::OP_ABS_SET: begin
            if (cmd_i.slot_a == tpft_pkg::SLOT_W'(i)) begin
              x_d[i]     = cmd_i.pos_x;
              y_d[i]     = cmd_i.pos_y;
              valid_d[i] = 1'b1;
            end
          end
          tpft_pkg::OP_ABS_DROP: begin
            if (cmd_i.slot_a == tpft_pkg::SLOT_W'(i)) begin
              valid_d[i] = 1'b0;
            end
          end
          tpft_pkg::OP_REL: begin
            // both deltas land when one finger is named twice
            x_d[i] = x_q[i]
              + ((cmd_i.slot_a_ok && cmd_i.slot_a == tpft_pkg::SLOT_W'(i))
                 ? {{8{cmd_i.dx_a[7]}}, cmd_i.dx_a} : 16'd0)
              + ((cmd_i.slot_b_ok && cmd_i.slot_b == tpft_pkg::SLOT_W'(i))
                 ? {{8{cmd_i.dx_b[7]}}, cmd_i.dx_b} : 16'd0);
            y_d[i] = y_q[i]
              + ((cmd_i.slot_a_ok && cmd_i.slot_a == tpft_pkg::SLOT_W'(i))
                 ? {{8{cmd_i.dy_a[7]}}, cmd_i.dy_a} : 16'd0)
              + ((cmd_i.slot_b_ok && cmd_i.slot_b == tpft_pkg::SLOT_W'(i))
                 ? {{8{cmd_i.dy_b[7]}}, cmd_i.dy_b} : 16'd0);
          end
          default: ;
        endcase
      end
    end
  end

  // report of slot cnt_q
  always_comb begin
    rep_touch = active_q[cnt_q] && valid_q[cnt_q];
    rep_x     = x_q[cnt_q];
    rep_y     = y_q[cnt_q];
    rep_yi    = (rep_touch && (y_limit_i > rep_y)) ? y_limit_i - rep_y : 16'd0;
  end

  // sequencing
  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    fault_d     = fault_q;
    out_valid_d = out_valid_q;
    if (load_en) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        if (cnt_q == tpft_pkg::LAST_SLOT) begin
          busy_d = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
    if (pop) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      fault_d = cmd_i.fault;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) begin
        x_q[i] <= '0;
        y_q[i] <= '0;
      end
      active_q    <= '0;
      valid_q     <= '0;
      button_q    <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      fault_q     <= tpft_pkg::FAULT_NONE;
      out_valid_q <= 1'b0;
    end else begin
      x_q         <= x_d;
      y_q         <= y_d;
      active_q    <= active_d;
      valid_q     <= valid_d;
      button_q    <= button_d;
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      fault_q     <= fault_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en && busy_q) begin
      out_slot_q   <= cnt_q;
      out_touch_q  <= rep_touch;
      out_x_q      <= rep_touch ? rep_x : 16'd0;
      out_y_q      <= rep_yi;
      out_button_q <= button_q;
      out_fault_q  <= fault_q;
      out_last_q   <= (cnt_q == tpft_pkg::LAST_SLOT);
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{tpft_pkg::OUT_PAD_W{1'b0}}, out_button_q, out_y_q,
                            out_x_q, out_touch_q, out_slot_q};
  assign m_axis_tuser_o  = out_fault_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== hdl/touchpad_packet_finger_tracker.sv =====
// ----------------------------------------------------------------------------
// touchpad_packet_finger_tracker - touchpad finger table
// Takes six-byte touchpad packets, keeps a per-finger position table and
// reports every finger slot after each packet.
//
//   channel   dir   item                 fields (low bit first)
//   s_axis    in    one 6-byte packet    tdata: byte_0..byte_5
//   m_axis    out   one slot report      tdata: slot, touching, pos_x,
//                                        pos_y_inverted, button, pad
//                                        tuser: fault  tlast: last
//   apb       in    register access      0 touch_type_code, 4 abs_type_code,
//                                        8 rel_type_code, 12 y_limit
//
// Each packet gives FINGER_SLOTS (5) reports, one per cycle while m_axis is not
// stalled, as the report counter of the table engine steps through the slots. A
// packet passes through the command queue and the table engine, whose output is
// registered. A two-entry command queue keeps s_axis open while reports stall, until full.
// Reset clears the finger table and button and loads the default type codes and y_limit.
// ----------------------------------------------------------------------------
module touchpad_packet_finger_tracker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // packet in: tdata = byte_0 .. byte_5
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [tpft_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  // report out: tdata = slot, touching, pos_x, pos_y_inverted, button
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [tpft_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  // tuser = fault
  output logic [1:0]                         m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tpft_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tpft_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tpft_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  tpft_pkg::type_codes_t codes_q, codes_d;
  logic [15:0]           y_limit_q, y_limit_d;
  tpft_pkg::reg_idx_e    reg_idx;
  logic                  reg_wr;

  tpft_pkg::cmd_t        front_cmd;
  tpft_pkg::cmd_t        q_cmd;
  logic                  q_full;
  logic                  q_valid;
  logic                  q_pop;

  // ---- registers ----
  assign pready  = 1'b1;
  assign reg_idx = tpft_pkg::reg_idx_e'(paddr[3:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    codes_d   = codes_q;
    y_limit_d = y_limit_q;
    if (reg_wr) begin
      case (reg_idx)
        tpft_pkg::REG_TOUCH_CODE: codes_d.touch_code = pwdata[3:0];
        tpft_pkg::REG_ABS_CODE:   codes_d.abs_code   = pwdata[3:0];
        tpft_pkg::REG_REL_CODE:   codes_d.rel_code   = pwdata[3:0];
        tpft_pkg::REG_Y_LIMIT:    y_limit_d          = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tpft_pkg::REG_TOUCH_CODE: prdata = {28'd0, codes_q.touch_code};
      tpft_pkg::REG_ABS_CODE:   prdata = {28'd0, codes_q.abs_code};
      tpft_pkg::REG_REL_CODE:   prdata = {28'd0, codes_q.rel_code};
      tpft_pkg::REG_Y_LIMIT:    prdata = {16'd0, y_limit_q};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.touch_code <= tpft_pkg::TOUCH_CODE_RST;
      codes_q.abs_code   <= tpft_pkg::ABS_CODE_RST;
      codes_q.rel_code   <= tpft_pkg::REL_CODE_RST;
      y_limit_q          <= tpft_pkg::Y_LIMIT_RST;
    end else begin
      codes_q   <= codes_d;
      y_limit_q <= y_limit_d;
    end
  end

  // ---- front: classify ----
  tpft_front u_front (
    .pkt_i   (s_axis_tdata_i),
    .codes_i (codes_q),
    .cmd_o   (front_cmd)
  );

  assign s_axis_tready_o = !q_full;

  // ---- queue ----
  tpft_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid_i),
    .push_data_i (front_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_cmd)
  );

  // ---- back: table update and reports ----
  tpft_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .y_limit_i       (y_limit_q),
    .cmd_valid_i     (q_valid),
    .cmd_i           (q_cmd),
    .cmd_pop_o       (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== hdl/tpft_checker.sv =====
// ----------------------------------------------------------------------------
// tpft_checker - port-level checks of the finger tracker
// Watches report framing and report content on the top-level ports.
// ----------------------------------------------------------------------------
module tpft_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [tpft_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [1:0]                       m_axis_tuser_o,
  input logic                             m_axis_tlast_o
);

  // no report while in reset
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("report valid during reset");

  // stalled report holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled report changed");

  // tlast marks exactly the final slot
  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tlast_o == (m_axis_tdata_o[2:0] == tpft_pkg::LAST_SLOT)))
    else $error("tlast not on final slot");

  // reports of one packet follow without gaps and share one fault code
  a_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (m_axis_tuser_o == $past(m_axis_tuser_o)))
    else $error("broken report run");

  // a slot not touching reports zero position
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[3] |-> (m_axis_tdata_o[35:4] == '0))
    else $error("position on non-touching slot");

endmodule

bind touchpad_packet_finger_tracker tpft_checker u_tpft_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench - touchpad finger tracker, self-checking stream test
// Streams six-byte packets into the tracker through a bursty driver and
// checks every slot report against a cycle-free model of the finger table.
// The register port moves the type codes and the pad height between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int HOLD_AFTER  = 120;     // reports taken before the hold-off

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

  // one expected slot report
  typedef struct {
    logic [tpft_pkg::SLOT_W-1:0] slot;
    logic                        touching;
    logic [15:0]                 pos_x;
    logic [15:0]                 pos_yi;
    logic                        button;
    tpft_pkg::fault_e            fault;
    logic                        last;
  } slot_report_t;

  // ---- DUT signals ---------------------------------------------------------
  logic                             clk_i   = 1'b0;
  logic                             rst_ni  = 1'b0;
  logic                             s_valid = 1'b0;
  logic                             s_ready;
  logic [tpft_pkg::IN_TDATA_W-1:0]  s_data  = '0;
  logic                             m_valid;
  logic                             m_ready = 1'b0;
  // slot, touching, pos_x, pos_y_inverted, button, pad
  logic [tpft_pkg::OUT_TDATA_W-1:0] m_data;
  logic [1:0]                       m_user;   // fault
  logic                             m_last;
  logic                             psel    = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite  = 1'b0;
  logic [tpft_pkg::APB_ADDR_W-1:0]  paddr   = '0;
  logic [tpft_pkg::APB_DATA_W-1:0]  pwdata  = '0;
  logic [tpft_pkg::APB_DATA_W-1:0]  prdata;
  logic                             pready;

  // ---- model state ---------------------------------------------------------
  logic [3:0]  cfg_touch = tpft_pkg::TOUCH_CODE_RST;
  logic [3:0]  cfg_abs   = tpft_pkg::ABS_CODE_RST;
  logic [3:0]  cfg_rel   = tpft_pkg::REL_CODE_RST;
  logic [15:0] cfg_ylim  = tpft_pkg::Y_LIMIT_RST;

  logic [15:0] fing_x   [tpft_pkg::FINGER_SLOTS] = '{default: '0};
  logic [15:0] fing_y   [tpft_pkg::FINGER_SLOTS] = '{default: '0};
  logic        fing_act [tpft_pkg::FINGER_SLOTS] = '{default: 1'b0};
  logic        fing_val [tpft_pkg::FINGER_SLOTS] = '{default: 1'b0};
  logic        btn_state = 1'b0;

  logic [tpft_pkg::IN_TDATA_W-1:0] pkt_backlog [$];   // requests waiting for the driver
  slot_report_t                    reports_due [$];   // reports owed by the DUT

  int mismatch_count = 0;
  int cycle_count    = 0;

  touchpad_packet_finger_tracker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d reports still owed", $time, reports_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---- finger table model --------------------------------------------------
  // signed byte delta, wraps at 16 bits
  function automatic logic [15:0] nudge(input logic [15:0] v, input logic [7:0] d);
    return v + {{8{d[7]}}, d};
  endfunction

  // apply one packet to the table and queue its FINGER_SLOTS reports
  function automatic void track_packet(input logic [tpft_pkg::IN_TDATA_W-1:0] pkt);
    logic [7:0]       b [6];
    tpft_pkg::fault_e fault;
    int               na;
    int               nb;
    slot_report_t     r;
    for (int i = 0; i < 6; i++) b[i] = pkt[8*i +: 8];
    fault = tpft_pkg::FAULT_NONE;
    // touch wins over absolute, absolute over relative when codes collide
    if (b[0][3:0] == cfg_touch) begin
      btn_state = b[0][4];
      for (int i = 0; i < tpft_pkg::FINGER_SLOTS; i++) begin
        fing_act[i] = b[1][i];
        if (!b[1][i]) fing_val[i] = 1'b0;
      end
    end else if (b[0][3:0] == cfg_abs) begin
      na = int'(b[1][7:4]);
      if (na == 0 || na > tpft_pkg::FINGER_SLOTS) begin
        fault = tpft_pkg::FAULT_FINGER;   // nothing changes, button included
      end else begin
        btn_state = b[0][4];
        if (b[5] == tpft_pkg::SIZE_LARGE) begin
          fing_val[na-1] = 1'b0;    // large contact: position kept
        end else begin
          fing_x[na-1]   = {4'h0, b[1][3:0], b[2]};
          fing_y[na-1]   = {b[3], b[4]};
          fing_val[na-1] = 1'b1;
        end
      end
    end else if (b[0][3:0] == cfg_rel) begin
      btn_state = b[0][7];
      na = int'(b[0][6:4]);
      nb = int'(b[3][6:4]);
      if (na == 0 || na > tpft_pkg::FINGER_SLOTS) begin
        fault = tpft_pkg::FAULT_FINGER;
      end else begin
        fing_x[na-1] = nudge(fing_x[na-1], b[1]);
        fing_y[na-1] = nudge(fing_y[na-1], b[2]);
      end
      // second finger missing or out of range is not a fault
      if (nb != 0 && nb <= tpft_pkg::FINGER_SLOTS) begin
        fing_x[nb-1] = nudge(fing_x[nb-1], b[4]);
        fing_y[nb-1] = nudge(fing_y[nb-1], b[5]);
      end
    end else begin
      fault = tpft_pkg::FAULT_TYPE;
    end

    for (int i = 0; i < tpft_pkg::FINGER_SLOTS; i++) begin
      r.slot     = tpft_pkg::SLOT_W'(i);
      r.touching = fing_act[i] && fing_val[i];
      r.pos_x    = r.touching ? fing_x[i] : 16'h0;
      r.pos_yi   = (r.touching && cfg_ylim > fing_y[i]) ? cfg_ylim - fing_y[i] : 16'h0;
      r.button   = btn_state;
      r.fault    = fault;
      r.last     = (i == tpft_pkg::FINGER_SLOTS - 1);
      reports_due.push_back(r);
    end
  endfunction

  // ---- packet builders -----------------------------------------------------
  function automatic logic [7:0] rbyte();
    return 8'($urandom);
  endfunction

  function automatic logic [tpft_pkg::IN_TDATA_W-1:0] pack6(
      input logic [7:0] b0, b1, b2, b3, b4, b5);
    return {b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic logic [tpft_pkg::IN_TDATA_W-1:0] touch_pkt(input logic btn,
                                                               input logic [7:0] map);
    return pack6({3'($urandom), btn, cfg_touch}, map, rbyte(), rbyte(), rbyte(), rbyte());
  endfunction

  function automatic logic [tpft_pkg::IN_TDATA_W-1:0] abs_pkt(
      input logic btn, input logic [3:0] num,
      input logic [11:0] x, input logic [15:0] y,
      input logic [7:0] size);
    return pack6({3'($urandom), btn, cfg_abs}, {num, x[11:8]}, x[7:0], y[15:8], y[7:0], size);
  endfunction

  function automatic logic [tpft_pkg::IN_TDATA_W-1:0] rel_pkt(
      input logic btn, input logic [2:0] na,
      input logic [7:0] dxa, dya,
      input logic [2:0] nb,
      input logic [7:0] dxb, dyb);
    return pack6({btn, na, cfg_rel}, dxa, dya, {1'($urandom), nb, 4'($urandom)}, dxb, dyb);
  endfunction

  // a type nibble that matches none of the programmed codes
  function automatic logic [3:0] stray_code();
    logic [3:0] t;
    do t = 4'($urandom_range(0, 15)); while (t == cfg_touch || t == cfg_abs || t == cfg_rel);
    return t;
  endfunction

  function automatic logic [tpft_pkg::IN_TDATA_W-1:0] random_pkt();
    logic [15:0] y;
    logic [3:0]  num;
    logic [2:0]  na;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick <= 2) begin
      return touch_pkt(1'($urandom), ($urandom_range(0, 1) == 0) ? rbyte() : (rbyte() | 8'h1f));
    end else if (pick <= 5) begin
      num = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 5));
      y   = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                        : cfg_ylim + 16'($urandom_range(0, 6)) - 16'd3;
      return abs_pkt(1'($urandom), num, 12'($urandom), y,
                     ($urandom_range(0, 9) == 0) ? tpft_pkg::SIZE_LARGE : rbyte());
    end else if (pick <= 8) begin
      na = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 5));
      return rel_pkt(1'($urandom), na, rbyte(), rbyte(), 3'($urandom_range(0, 7)),
                     rbyte(), rbyte());
    end else if ($urandom_range(0, 1) == 0) begin
      return pack6({rbyte() & 8'hf0} | 8'(stray_code()), rbyte(), rbyte(), rbyte(),
                   rbyte(), rbyte());
    end else begin
      return {16'($urandom), 32'($urandom)};   // raw noise, any type
    end
  endfunction

  // ---- packet driver: bursts of requests with random gaps ----------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin : pkt_driver
    logic taken;
    taken = s_valid && s_ready;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (taken) track_packet(s_data);
      if (!s_valid || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (pkt_backlog.size() > 0) begin
          s_data  <= pkt_backlog.pop_front();
          s_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---- report receiver: own stall pattern plus one long hold-off ---------
  rx_mode_e rx_mode    = RX_OPEN;
  int       rx_seg     = 0;
  int       rx_taken   = 0;
  int       hold_left  = 0;
  bit       hold_done  = 1'b0;

  always @(posedge clk_i) begin : rpt_receiver
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) rx_taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (!hold_done && rx_taken >= HOLD_AFTER) begin
        // sender keeps going, so the command queue fills and s_axis stalls
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_ready <= 1'b0;
      end else begin
        if (rx_seg <= 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          rx_seg  = $urandom_range(8, 60);
        end
        rx_seg--;
        case (rx_mode)
          RX_OPEN: m_ready <= 1'b1;
          RX_COIN: m_ready <= 1'($urandom_range(0, 1));
          default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---- report checker ------------------------------------------------------
  task automatic flag_field(input string name, input logic [15:0] want, got);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : rpt_checker
    slot_report_t want;
    if (rst_ni && m_valid && m_ready) begin
      if (reports_due.size() == 0) begin
        $display("%0t: report with nothing owed, expected none, got %0h", $time, m_data);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        if (m_data[2:0] !== want.slot)       flag_field("slot", 16'(want.slot), 16'(m_data[2:0]));
        if (m_data[3] !== want.touching)     flag_field("touching", 16'(want.touching),
                                                        16'(m_data[3]));
        if (m_data[19:4] !== want.pos_x)     flag_field("pos_x", want.pos_x, m_data[19:4]);
        if (m_data[35:20] !== want.pos_yi)   flag_field("pos_y_inverted", want.pos_yi,
                                                        m_data[35:20]);
        if (m_data[36] !== want.button)      flag_field("button", 16'(want.button),
                                                        16'(m_data[36]));
        if (m_data[39:37] !== '0)            flag_field("pad", 16'h0, 16'(m_data[39:37]));
        if (m_user !== want.fault)           flag_field("fault", 16'(want.fault), 16'(m_user));
        if (m_last !== want.last)            flag_field("last", 16'(want.last), 16'(m_last));
      end
    end
  end

  // ---- register writes and sequencing --------------------------------------
  task automatic reg_write(input tpft_pkg::reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);             // register taken here
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      tpft_pkg::REG_TOUCH_CODE: cfg_touch = val[3:0];
      tpft_pkg::REG_ABS_CODE:   cfg_abs   = val[3:0];
      tpft_pkg::REG_REL_CODE:   cfg_rel   = val[3:0];
      default:                  cfg_ylim  = val[15:0];
    endcase
  endtask

  task automatic set_codes(input logic [3:0] t, a, r, input logic [15:0] ylim);
    reg_write(tpft_pkg::REG_TOUCH_CODE, 32'(t));
    reg_write(tpft_pkg::REG_ABS_CODE, 32'(a));
    reg_write(tpft_pkg::REG_REL_CODE, 32'(r));
    reg_write(tpft_pkg::REG_Y_LIMIT, 32'(ylim));
  endtask

  // sender holds until every owed report is in, plus the pipeline depth
  task automatic wait_drained();
    do @(negedge clk_i); while (pkt_backlog.size() != 0 || s_valid || reports_due.size() != 0);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic push_random(input int n);
    repeat (n) pkt_backlog.push_back(random_pkt());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: default codes
    pkt_backlog.push_back(touch_pkt(1'b1, 8'hff));      // bitmap bits past the table ignored
    pkt_backlog.push_back(abs_pkt(1'b0, 4'd1, 12'h000, 16'h0000, 8'h10));
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd2, 12'hfff, 16'hffff, 8'h00));
    pkt_backlog.push_back(abs_pkt(1'b0, 4'd3, 12'h800, 16'd32640, 8'hfe));
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd4, 12'h7ff, 16'd32639, 8'h01));
    pkt_backlog.push_back(abs_pkt(1'b0, 4'd5, 12'h001, 16'd32641, 8'h80));
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd0, 12'h123, 16'h4567, 8'h20));   // no finger
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd6, 12'h321, 16'h7654, 8'h20));   // just past table
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd15, 12'hfff, 16'hffff, 8'hff));  // far past table
    pkt_backlog.push_back(abs_pkt(1'b0, 4'd2, 12'h555, 16'h1234, tpft_pkg::SIZE_LARGE));
    pkt_backlog.push_back(rel_pkt(1'b1, 3'd1, 8'h7f, 8'h80, 3'd0, 8'h11, 8'h22));
    pkt_backlog.push_back(rel_pkt(1'b0, 3'd3, 8'hff, 8'h01, 3'd3, 8'h80, 8'h7f)); // same twice
    pkt_backlog.push_back(rel_pkt(1'b1, 3'd0, 8'h05, 8'h06, 3'd2, 8'h07, 8'h08)); // first absent
    pkt_backlog.push_back(rel_pkt(1'b0, 3'd6, 8'h05, 8'h06, 3'd7, 8'h07, 8'h08)); // both bad
    pkt_backlog.push_back(rel_pkt(1'b1, 3'd5, 8'hc0, 8'h40, 3'd6, 8'h01, 8'h01));
    pkt_backlog.push_back(abs_pkt(1'b0, 4'd1, 12'h000, 16'h0000, 8'h00));
    pkt_backlog.push_back(rel_pkt(1'b0, 3'd1, 8'hff, 8'hff, 3'd0, 8'h00, 8'h00)); // wrap below 0
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd4, 12'hfff, 16'hffff, 8'h00));
    pkt_backlog.push_back(rel_pkt(1'b1, 3'd4, 8'h7f, 8'h7f, 3'd4, 8'h7f, 8'h7f)); // wrap above
    pkt_backlog.push_back(pack6({4'ha, stray_code()}, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    pkt_backlog.push_back(touch_pkt(1'b0, 8'h00));      // drops every valid
    pkt_backlog.push_back(touch_pkt(1'b1, 8'h1f));
    pkt_backlog.push_back(abs_pkt(1'b1, 4'd3, 12'habc, 16'h0100, 8'h30));
    push_random(60);
    wait_drained();

    // extreme codes, tallest pad
    set_codes(4'd0, 4'd15, 4'd7, 16'hffff);
    push_random(50);
    wait_drained();

    // all codes equal: every packet with that code decodes as touch
    set_codes(4'd5, 4'd5, 4'd5, 16'h0000);
    push_random(10);
    wait_drained();

    // absolute and relative share a code: absolute wins
    set_codes(4'd1, 4'd2, 4'd2, 16'h8000);
    push_random(10);
    wait_drained();

    // short pad, so inverted y often saturates
    set_codes(4'd15, 4'd0, 4'd8, 16'd1000);
    push_random(70);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
